// ===== hdl/assert_macros.svh =====
// Assertion helpers used by the checker module of this block.
// Every property is sampled on the rising edge of clk and is switched off
// while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every sampled edge.
`define SIT_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("sit checker: property failed");

// A condition that, when true, must be followed by another at the next edge.
`define SIT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sit checker: next-cycle property failed");

`endif

// ===== hdl/sit_pkg.sv =====
// ----------------------------------------------------------------------------
// sit_pkg: shared types and constants of the segment intersection test
// Coordinate widths, derived arithmetic widths, the transaction payloads and
// the stage payloads that pass between the pipeline modules.
// ----------------------------------------------------------------------------
package sit_pkg;

  localparam int COORD_WIDTH = 16;
  // Width of a coordinate difference.
  localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
  // Width of products, cross products and the scaled bounds.
  localparam int PROD_WIDTH  = 2 * COORD_WIDTH + 3;

  typedef enum logic [1:0] {
    REL_CROSS    = 2'd0,
    REL_COINCIDE = 2'd1,
    REL_PARALLEL = 2'd2
  } sit_rel_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] first_start_x;
    logic signed [COORD_WIDTH-1:0] first_start_y;
    logic signed [COORD_WIDTH-1:0] first_end_x;
    logic signed [COORD_WIDTH-1:0] first_end_y;
    logic signed [COORD_WIDTH-1:0] second_start_x;
    logic signed [COORD_WIDTH-1:0] second_start_y;
    logic signed [COORD_WIDTH-1:0] second_end_x;
    logic signed [COORD_WIDTH-1:0] second_end_y;
  } sit_in_t;

  typedef struct packed {
    logic     collide;
    sit_rel_t relation;
  } sit_out_t;

  // Facts about the pair that ride along with the arithmetic.
  typedef struct packed {
    logic signed [DIFF_WIDTH-1:0] uy_raw;
    logic signed [DIFF_WIDTH-1:0] vy_raw;
    logic                         u_vert;
    logic                         v_vert;
    logic                         box_overlap;
  } sit_ctx_t;

  // Direction vectors (vertical ones already replaced by (0, 1)).
  typedef struct packed {
    logic signed [DIFF_WIDTH-1:0] ux;
    logic signed [DIFF_WIDTH-1:0] uy;
    logic signed [DIFF_WIDTH-1:0] vx;
    logic signed [DIFF_WIDTH-1:0] vy;
    logic signed [DIFF_WIDTH-1:0] wx;
    logic signed [DIFF_WIDTH-1:0] wy;
    sit_ctx_t                     ctx;
  } sit_diff_t;

  // Denominator and the two parameter numerators.
  typedef struct packed {
    logic signed [PROD_WIDTH-1:0] den;
    logic signed [PROD_WIDTH-1:0] tn;
    logic signed [PROD_WIDTH-1:0] sn;
    sit_ctx_t                     ctx;
  } sit_cross_t;

endpackage

// ===== hdl/sit_setup.sv =====
// ----------------------------------------------------------------------------
// sit_setup: first pipeline stage
// Forms the direction vectors of both segments and the offset between their
// starts, flags vertical segments and settles the bounding box overlap.
// ----------------------------------------------------------------------------
module sit_setup (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sit_pkg::sit_in_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output sit_pkg::sit_diff_t out_data
);

  localparam int DW = sit_pkg::DIFF_WIDTH;

  logic               valid_r;
  sit_pkg::sit_diff_t stage_r;
  sit_pkg::sit_diff_t stage_nxt;

  logic signed [DW-1:0] ax;
  logic signed [DW-1:0] ay;
  logic signed [DW-1:0] bx;
  logic signed [DW-1:0] by;
  logic signed [DW-1:0] cx;
  logic signed [DW-1:0] cy;
  logic signed [DW-1:0] dx;
  logic signed [DW-1:0] dy;
  logic signed [DW-1:0] ux;
  logic signed [DW-1:0] uy;
  logic signed [DW-1:0] vx;
  logic signed [DW-1:0] vy;
  logic signed [DW-1:0] x1lo;
  logic signed [DW-1:0] x1hi;
  logic signed [DW-1:0] y1lo;
  logic signed [DW-1:0] y1hi;
  logic signed [DW-1:0] x2lo;
  logic signed [DW-1:0] x2hi;
  logic signed [DW-1:0] y2lo;
  logic signed [DW-1:0] y2hi;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = stage_r;

  always_comb begin
    ax = DW'(in_data.first_start_x);
    ay = DW'(in_data.first_start_y);
    bx = DW'(in_data.first_end_x);
    by = DW'(in_data.first_end_y);
    cx = DW'(in_data.second_start_x);
    cy = DW'(in_data.second_start_y);
    dx = DW'(in_data.second_end_x);
    dy = DW'(in_data.second_end_y);

    ux = bx - ax;
    uy = by - ay;
    vx = dx - cx;
    vy = dy - cy;

    x1lo = (ax < bx) ? ax : bx;
    x1hi = (ax < bx) ? bx : ax;
    y1lo = (ay < by) ? ay : by;
    y1hi = (ay < by) ? by : ay;
    x2lo = (cx < dx) ? cx : dx;
    x2hi = (cx < dx) ? dx : cx;
    y2lo = (cy < dy) ? cy : dy;
    y2hi = (cy < dy) ? dy : cy;

    stage_nxt.ctx.uy_raw      = uy;
    stage_nxt.ctx.vy_raw      = vy;
    stage_nxt.ctx.u_vert      = (ux == '0);
    stage_nxt.ctx.v_vert      = (vx == '0);
    stage_nxt.ctx.box_overlap = (x1lo <= x2hi) && (x2lo <= x1hi) &&
                                (y1lo <= y2hi) && (y2lo <= y1hi);

    // A vertical segment is treated as the line x = start x, direction (0, 1).
    stage_nxt.ux = ux;
    stage_nxt.uy = (ux == '0) ? DW'(1) : uy;
    stage_nxt.vx = vx;
    stage_nxt.vy = (vx == '0) ? DW'(1) : vy;
    stage_nxt.wx = cx - ax;
    stage_nxt.wy = cy - ay;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage_r <= stage_nxt;
    end
  end

endmodule

// ===== hdl/sit_cross.sv =====
// ----------------------------------------------------------------------------
// sit_cross: second and third pipeline stages
// Registers the six partial products, then subtracts them into the
// denominator and the numerators of both line parameters.
// ----------------------------------------------------------------------------
module sit_cross (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sit_pkg::sit_diff_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sit_pkg::sit_cross_t out_data
);

  localparam int DW = sit_pkg::DIFF_WIDTH;
  localparam int PW = sit_pkg::PROD_WIDTH;

  typedef struct packed {
    logic signed [PW-1:0] ux_vy;
    logic signed [PW-1:0] uy_vx;
    logic signed [PW-1:0] wx_vy;
    logic signed [PW-1:0] wy_vx;
    logic signed [PW-1:0] wx_uy;
    logic signed [PW-1:0] wy_ux;
    sit_pkg::sit_ctx_t    ctx;
  } prod_t;

  logic                valid2_r;
  logic                valid3_r;
  logic                ready2;
  logic                ready3;
  prod_t               prod_r;
  prod_t               prod_nxt;
  sit_pkg::sit_cross_t cross_r;
  sit_pkg::sit_cross_t cross_nxt;

  logic signed [2*DW-1:0] m_ux_vy;
  logic signed [2*DW-1:0] m_uy_vx;
  logic signed [2*DW-1:0] m_wx_vy;
  logic signed [2*DW-1:0] m_wy_vx;
  logic signed [2*DW-1:0] m_wx_uy;
  logic signed [2*DW-1:0] m_wy_ux;

  assign ready3    = !valid3_r || out_ready;
  assign ready2    = !valid2_r || ready3;
  assign in_ready  = ready2;
  assign out_valid = valid3_r;
  assign out_data  = cross_r;

  assign m_ux_vy = (2*DW)'(in_data.ux) * (2*DW)'(in_data.vy);
  assign m_uy_vx = (2*DW)'(in_data.uy) * (2*DW)'(in_data.vx);
  assign m_wx_vy = (2*DW)'(in_data.wx) * (2*DW)'(in_data.vy);
  assign m_wy_vx = (2*DW)'(in_data.wy) * (2*DW)'(in_data.vx);
  assign m_wx_uy = (2*DW)'(in_data.wx) * (2*DW)'(in_data.uy);
  assign m_wy_ux = (2*DW)'(in_data.wy) * (2*DW)'(in_data.ux);

  always_comb begin
    prod_nxt.ux_vy = PW'(m_ux_vy);
    prod_nxt.uy_vx = PW'(m_uy_vx);
    prod_nxt.wx_vy = PW'(m_wx_vy);
    prod_nxt.wy_vx = PW'(m_wy_vx);
    prod_nxt.wx_uy = PW'(m_wx_uy);
    prod_nxt.wy_ux = PW'(m_wy_ux);
    prod_nxt.ctx   = in_data.ctx;
  end

  // The crossing sits at start1 + (tn/den) * u and at start2 + (sn/den) * v.
  // The sn numerator is also the collinearity test when den is zero.
  always_comb begin
    cross_nxt.den = prod_r.ux_vy - prod_r.uy_vx;
    cross_nxt.tn  = prod_r.wx_vy - prod_r.wy_vx;
    cross_nxt.sn  = prod_r.wx_uy - prod_r.wy_ux;
    cross_nxt.ctx = prod_r.ctx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid2_r <= 1'b0;
      valid3_r <= 1'b0;
    end else begin
      if (ready2) begin
        valid2_r <= in_valid;
      end
      if (ready3) begin
        valid3_r <= valid2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready2 && in_valid) begin
      prod_r <= prod_nxt;
    end
    if (ready3 && valid2_r) begin
      cross_r <= cross_nxt;
    end
  end

endmodule

// ===== hdl/sit_resolve.sv =====
// ----------------------------------------------------------------------------
// sit_resolve: fourth to sixth pipeline stages
// Makes the denominator positive, scales the parameter bounds of vertical
// segments, then compares both parameters with their bounds and classifies
// the pair into crossing, coinciding or parallel lines.
// ----------------------------------------------------------------------------
module sit_resolve (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sit_pkg::sit_cross_t in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sit_pkg::sit_out_t   out_data
);

  localparam int DW = sit_pkg::DIFF_WIDTH;
  localparam int PW = sit_pkg::PROD_WIDTH;

  typedef struct packed {
    logic signed [PW-1:0] den_mag;
    logic signed [PW-1:0] tn;
    logic signed [PW-1:0] sn;
    logic                 den_zero;
    logic                 sn_zero;
    sit_pkg::sit_ctx_t    ctx;
  } norm_t;

  typedef struct packed {
    logic signed [PW-1:0] t_lo;
    logic signed [PW-1:0] t_hi;
    logic signed [PW-1:0] s_lo;
    logic signed [PW-1:0] s_hi;
    logic signed [PW-1:0] tn;
    logic signed [PW-1:0] sn;
    logic                 den_zero;
    logic                 sn_zero;
    logic                 box_overlap;
  } bound_t;

  logic              valid4_r;
  logic              valid5_r;
  logic              valid6_r;
  logic              ready4;
  logic              ready5;
  logic              ready6;
  norm_t             norm_r;
  norm_t             norm_nxt;
  bound_t            bound_r;
  bound_t            bound_nxt;
  sit_pkg::sit_out_t res_r;
  sit_pkg::sit_out_t res_nxt;

  logic                 den_neg;
  logic signed [DW:0]   den_low;
  logic signed [PW-1:0] pu;
  logic signed [PW-1:0] pv;

  assign ready6    = !valid6_r || out_ready;
  assign ready5    = !valid5_r || ready6;
  assign ready4    = !valid4_r || ready5;
  assign in_ready  = ready4;
  assign out_valid = valid6_r;
  assign out_data  = res_r;

  always_comb begin
    den_neg           = in_data.den[PW-1];
    norm_nxt.den_mag  = den_neg ? -in_data.den : in_data.den;
    norm_nxt.tn       = den_neg ? -in_data.tn : in_data.tn;
    norm_nxt.sn       = den_neg ? -in_data.sn : in_data.sn;
    norm_nxt.den_zero = (in_data.den == '0);
    norm_nxt.sn_zero  = (in_data.sn == '0);
    norm_nxt.ctx      = in_data.ctx;
  end

  // A vertical segment with a crossing forces den to plus or minus the other segment's
  // x step, so its magnitude fits in DW bits and the bound product stays small.
  assign den_low = $signed({1'b0, norm_r.den_mag[DW-1:0]});
  assign pu      = PW'(norm_r.ctx.uy_raw) * PW'(den_low);
  assign pv      = PW'(norm_r.ctx.vy_raw) * PW'(den_low);

  always_comb begin
    if (norm_r.ctx.u_vert) begin
      bound_nxt.t_lo = norm_r.ctx.uy_raw[DW-1] ? pu : '0;
      bound_nxt.t_hi = norm_r.ctx.uy_raw[DW-1] ? '0 : pu;
    end else begin
      bound_nxt.t_lo = '0;
      bound_nxt.t_hi = norm_r.den_mag;
    end
    if (norm_r.ctx.v_vert) begin
      bound_nxt.s_lo = norm_r.ctx.vy_raw[DW-1] ? pv : '0;
      bound_nxt.s_hi = norm_r.ctx.vy_raw[DW-1] ? '0 : pv;
    end else begin
      bound_nxt.s_lo = '0;
      bound_nxt.s_hi = norm_r.den_mag;
    end
    bound_nxt.tn          = norm_r.tn;
    bound_nxt.sn          = norm_r.sn;
    bound_nxt.den_zero    = norm_r.den_zero;
    bound_nxt.sn_zero     = norm_r.sn_zero;
    bound_nxt.box_overlap = norm_r.ctx.box_overlap;
  end

  always_comb begin
    if (bound_r.den_zero) begin
      res_nxt.relation = bound_r.sn_zero ? sit_pkg::REL_COINCIDE : sit_pkg::REL_PARALLEL;
      res_nxt.collide  = bound_r.sn_zero && bound_r.box_overlap;
    end else begin
      res_nxt.relation = sit_pkg::REL_CROSS;
      res_nxt.collide  = (bound_r.t_lo <= bound_r.tn) && (bound_r.tn <= bound_r.t_hi) &&
                         (bound_r.s_lo <= bound_r.sn) && (bound_r.sn <= bound_r.s_hi);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid4_r <= 1'b0;
      valid5_r <= 1'b0;
      valid6_r <= 1'b0;
    end else begin
      if (ready4) begin
        valid4_r <= in_valid;
      end
      if (ready5) begin
        valid5_r <= valid4_r;
      end
      if (ready6) begin
        valid6_r <= valid5_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready4 && in_valid) begin
      norm_r <= norm_nxt;
    end
    if (ready5 && valid4_r) begin
      bound_r <= bound_nxt;
    end
    if (ready6 && valid5_r) begin
      res_r <= res_nxt;
    end
  end

endmodule

// ===== hdl/segment_intersection_test_unit.sv =====
// ----------------------------------------------------------------------------
// segment_intersection_test_unit: 2D segment pair intersection test
// Usage:
//   The in_ channel carries one pair of segments per transaction (two
//   endpoints each, signed integer coordinates). The out_ channel returns
//   one result per pair, in order: collide, and the relation of the two
//   supporting lines (crossing, coinciding, parallel and distinct).
//   Both channels use valid and ready; a transaction completes on a rising
//   edge with valid and ready high.
//   An accepted pair passes through six registered stages to its result
//   on out_valid: one setup stage, two cross product stages and three
//   resolve stages. Throughput is one pair per cycle while out_ready is
//   high; each stage holds one pair, so the rate is set by the stage
//   registers and the multiplier stage that forms the six partial products.
//   Every stage has its own valid bit and takes a new pair whenever it is
//   empty or its contents move on, so bubbles close up while the output
//   is stalled. When the receiver holds out_ready low, the result stays on
//   out_data and in_ready drops once all six stages are full.
//   A synchronous reset (rst_n low) empties the pipeline; no results are
//   in flight afterwards.
// ----------------------------------------------------------------------------
module segment_intersection_test_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sit_pkg::sit_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output sit_pkg::sit_out_t out_data
);

  logic                setup_valid;
  logic                setup_ready;
  sit_pkg::sit_diff_t  setup_data;
  logic                cross_valid;
  logic                cross_ready;
  sit_pkg::sit_cross_t cross_data;

  sit_setup u_setup (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (setup_valid),
    .out_ready (setup_ready),
    .out_data  (setup_data)
  );

  sit_cross u_cross (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (setup_valid),
    .in_ready  (setup_ready),
    .in_data   (setup_data),
    .out_valid (cross_valid),
    .out_ready (cross_ready),
    .out_data  (cross_data)
  );

  sit_resolve u_resolve (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cross_valid),
    .in_ready  (cross_ready),
    .in_data   (cross_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== hdl/sit_checker.sv =====
// ----------------------------------------------------------------------------
// sit_checker: port-level assertions for the segment intersection test
// Watches only the top-level ports and is attached by the bind below.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sit_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input sit_pkg::sit_in_t  in_data,
  input logic              out_valid,
  input logic              out_ready,
  input sit_pkg::sit_out_t out_data
);

  logic in_seen;

  // Keeps the input payload part of the checked interface.
  assign in_seen = in_valid && in_ready && (in_data == in_data);

  // Parallel, distinct lines never touch.
  `SIT_ASSERT(a_parallel_no_hit, (out_valid && out_data.relation == sit_pkg::REL_PARALLEL) |-> !out_data.collide)

  // With the output slot free or draining, the pipeline has room for a pair.
  `SIT_ASSERT(a_ready_chain, ((!out_valid || out_ready) && !in_seen) |-> in_ready)

  // A stalled result holds its value.
  `SIT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

endmodule

bind segment_intersection_test_unit sit_checker u_sit_checker (.*);

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench for segment_intersection_test_unit
// Streams segment pairs through the block with random gaps on the input side
// and random stalls on the result side. Each accepted pair is run through an
// exact wide-integer model of the intersection test, and every result is
// checked in order against the verdict that model predicts.
// ----------------------------------------------------------------------------
module tb;

  typedef logic signed [sit_pkg::COORD_WIDTH-1:0] coord_t;
  // Wide enough to hold every product of the test without overflow.
  typedef logic signed [127:0] wide_t;

  class verdict_board;
    sit_pkg::sit_out_t pending_verdicts[$];
    int                mismatches;

    function new();
      mismatches = 0;
    endfunction

    // Borders count: lo * den <= num <= hi * den, with den positive.
    function bit on_span(wide_t num, wide_t den, wide_t lo, wide_t hi);
      return (lo * den <= num) && (num <= hi * den);
    endfunction

    function sit_pkg::sit_out_t segment_touch_verdict(sit_pkg::sit_in_t p);
      wide_t             ax, ay, bx, by, cx, cy, dx, dy;
      wide_t             ux, uy, vx, vy, wx, wy, den, tn, px, py;
      wide_t             x1lo, x1hi, y1lo, y1hi, x2lo, x2hi, y2lo, y2hi;
      sit_pkg::sit_out_t v;
      ax = wide_t'(p.first_start_x);
      ay = wide_t'(p.first_start_y);
      bx = wide_t'(p.first_end_x);
      by = wide_t'(p.first_end_y);
      cx = wide_t'(p.second_start_x);
      cy = wide_t'(p.second_start_y);
      dx = wide_t'(p.second_end_x);
      dy = wide_t'(p.second_end_y);
      x1lo = (ax < bx) ? ax : bx;
      x1hi = (ax < bx) ? bx : ax;
      y1lo = (ay < by) ? ay : by;
      y1hi = (ay < by) ? by : ay;
      x2lo = (cx < dx) ? cx : dx;
      x2hi = (cx < dx) ? dx : cx;
      y2lo = (cy < dy) ? cy : dy;
      y2hi = (cy < dy) ? dy : cy;
      ux = bx - ax;
      uy = by - ay;
      vx = dx - cx;
      vy = dy - cy;
      wx = cx - ax;
      wy = cy - ay;
      // A segment with equal x stands for the vertical line through its start.
      if (ux == 0) uy = wide_t'(1);
      if (vx == 0) vy = wide_t'(1);
      den = ux * vy - uy * vx;
      v.collide = 1'b0;
      if (den == 0) begin
        if (wx * uy - wy * ux == 0) begin
          v.relation = sit_pkg::REL_COINCIDE;
          v.collide  = (x1lo <= x2hi) && (x2lo <= x1hi) && (y1lo <= y2hi) && (y2lo <= y1hi);
        end else begin
          v.relation = sit_pkg::REL_PARALLEL;
        end
      end else begin
        v.relation = sit_pkg::REL_CROSS;
        // The crossing point is (px / den, py / den).
        tn = wx * vy - wy * vx;
        px = ax * den + tn * ux;
        py = ay * den + tn * uy;
        if (den < 0) begin
          den = -den;
          px  = -px;
          py  = -py;
        end
        v.collide = on_span(px, den, x1lo, x1hi) && on_span(px, den, x2lo, x2hi) &&
                    on_span(py, den, y1lo, y1hi) && on_span(py, den, y2lo, y2hi);
      end
      return v;
    endfunction

    function void note_pair(sit_pkg::sit_in_t p);
      pending_verdicts.push_back(segment_touch_verdict(p));
    endfunction

    function void check_verdict(sit_pkg::sit_out_t got);
      sit_pkg::sit_out_t want;
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: collide=%0d relation=%0d", got.collide, got.relation);
        return;
      end
      want = pending_verdicts.pop_front();
      if (got.collide !== want.collide || got.relation !== want.relation) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected collide=%0d relation=%0d, got collide=%0d relation=%0d",
                   want.collide, want.relation, got.collide, got.relation);
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  sit_pkg::sit_in_t  in_data;
  logic              out_valid;
  logic              out_ready;
  sit_pkg::sit_out_t out_data;

  verdict_board board;
  // When set, neither side idles.
  bit           steady;

  segment_intersection_test_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("status: fail");
    $finish;
  end

  function automatic int idle_len();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int stall_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  function automatic sit_pkg::sit_in_t mk(input int a, b, c, d, e, f, g, h);
    sit_pkg::sit_in_t p;
    p.first_start_x  = coord_t'(a);
    p.first_start_y  = coord_t'(b);
    p.first_end_x    = coord_t'(c);
    p.first_end_y    = coord_t'(d);
    p.second_start_x = coord_t'(e);
    p.second_start_y = coord_t'(f);
    p.second_end_x   = coord_t'(g);
    p.second_end_y   = coord_t'(h);
    return p;
  endfunction

  function automatic int sg();
    return int'($urandom_range(0, 12)) - 6;
  endfunction

  function automatic int extreme_coord();
    int picks[7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};
    return picks[$urandom_range(0, 6)];
  endfunction

  function automatic sit_pkg::sit_in_t random_pair();
    int r, bx0, by0, dx0, dy0, ox, oy, x1, x2, k0, k1, k2, k3;
    r   = $urandom_range(0, 99);
    bx0 = int'($urandom_range(0, 2000)) - 1000;
    by0 = int'($urandom_range(0, 2000)) - 1000;
    dx0 = int'($urandom_range(0, 40)) - 20;
    dy0 = int'($urandom_range(0, 40)) - 20;
    k0  = int'($urandom_range(0, 10)) - 5;
    k1  = int'($urandom_range(0, 10)) - 5;
    k2  = int'($urandom_range(0, 10)) - 5;
    k3  = int'($urandom_range(0, 10)) - 5;
    if (r < 15)
      return sit_pkg::sit_in_t'({$urandom(), $urandom(), $urandom(), $urandom()});
    if (r < 35) return mk(sg(), sg(), sg(), sg(), sg(), sg(), sg(), sg());
    // Four points on one line: coinciding segments, overlapping or not.
    if (r < 50)
      return mk(bx0 + k0 * dx0, by0 + k0 * dy0, bx0 + k1 * dx0, by0 + k1 * dy0,
                bx0 + k2 * dx0, by0 + k2 * dy0, bx0 + k3 * dx0, by0 + k3 * dy0);
    if (r < 60) begin
      ox = sg();
      oy = sg();
      return mk(bx0, by0, bx0 + dx0, by0 + dy0, bx0 + ox, by0 + oy,
                bx0 + dx0 + ox, by0 + dy0 + oy);
    end
    if (r < 70) begin
      x1 = sg();
      x2 = ($urandom_range(0, 1) != 0) ? x1 : sg();
      if ($urandom_range(0, 2) == 0) return mk(x1, sg(), x1, sg(), sg(), sg(), sg(), sg());
      return mk(x1, sg(), x1, sg(), x2, sg(), x2, sg());
    end
    // Degenerate point segments, sometimes centered on the other segment.
    if (r < 78) begin
      x1 = sg();
      x2 = sg();
      if ($urandom_range(0, 1) != 0)
        return mk(x1, x2, x1, x2, x1 - dx0, x2 - dy0, x1 + dx0, x2 + dy0);
      return mk(x1, x2, x1, x2, sg(), sg(), sg(), sg());
    end
    // The second segment starts on the first one.
    if (r < 88) begin
      k0 = $urandom_range(0, 2);
      return mk(bx0, by0, bx0 + 2 * dx0, by0 + 2 * dy0, bx0 + k0 * dx0, by0 + k0 * dy0,
                bx0 + sg() * 7, by0 + sg() * 7);
    end
    return mk(extreme_coord(), extreme_coord(), extreme_coord(), extreme_coord(),
              extreme_coord(), extreme_coord(), extreme_coord(), extreme_coord());
  endfunction

  task automatic push_pair(input sit_pkg::sit_in_t p);
    int gap;
    gap = idle_len();
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_data  = p;
    do @(posedge clk); while (!in_ready);
    board.note_pair(p);
  endtask

  task automatic run_directed();
    push_pair(mk(0, 0, 4, 4, 0, 4, 4, 0));
    push_pair(mk(0, 0, 1, 1, 3, 5, 4, 5));
    push_pair(mk(0, 0, 2, 2, 2, 2, 5, 0));
    push_pair(mk(0, 0, 4, 4, 2, 2, 6, 6));
    push_pair(mk(0, 0, 1, 1, 3, 3, 5, 5));
    // Containment in both directions.
    push_pair(mk(2, 2, 3, 3, 0, 0, 6, 6));
    push_pair(mk(0, 0, 6, 6, 2, 2, 3, 3));
    push_pair(mk(0, 0, 4, 4, 0, 1, 4, 5));
    // Both vertical: same x overlapping, same x apart, different x; then vertical against horizontal.
    push_pair(mk(3, 0, 3, 5, 3, 4, 3, 9));
    push_pair(mk(3, 0, 3, 2, 3, 4, 3, 9));
    push_pair(mk(3, 0, 3, 5, 4, 0, 4, 5));
    push_pair(mk(2, -3, 2, 3, -5, 0, 5, 0));
    push_pair(mk(2, 1, 2, 3, -5, 0, 5, 0));
    // Point segments.
    push_pair(mk(2, 2, 2, 2, 0, 0, 4, 4));
    push_pair(mk(2, 3, 2, 3, 0, 0, 4, 4));
    push_pair(mk(5, 5, 5, 5, 5, 5, 5, 5));
    push_pair(mk(1, 1, 1, 1, 2, 2, 2, 2));
    push_pair(mk(1, 1, 1, 1, 1, 4, 1, 4));
    // Extremes of the coordinate range.
    push_pair(mk(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
    push_pair(mk(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    push_pair(mk(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    push_pair(mk(-32768, 32767, 32767, 32767, 32767, -32768, 32767, 32767));
    push_pair(mk(32767, -32768, -32768, 32767, -32768, -32767, 32767, 32766));
    push_pair(mk(-32768, 0, 32767, 1, 0, -32768, 1, 32767));
  endtask

  initial begin
    int hold;
    hold      = 0;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_ready = 1'b0;
        hold--;
      end else begin
        out_ready = 1'b1;
        if (!steady && $urandom_range(0, 3) == 0) hold = stall_len();
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_verdict(out_data);
  end

  initial begin
    int n;
    board    = new();
    steady   = 1'b0;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    run_directed();
    for (n = 0; n < 530; n++) begin
      if (n % 40 == 0) steady = ($urandom_range(0, 3) == 0);
      push_pair(random_pair());
    end
    @(negedge clk);
    in_valid = 1'b0;
    steady   = 1'b0;

    while (board.pending_verdicts.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (board.mismatches == 0 && board.pending_verdicts.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
